FILE: hdl/dds_pkg.sv
// Shared types, codes and arithmetic helpers for the straight-drive controller.
`default_nettype none

package dds_pkg;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RATIO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE = 3'd4;

    localparam logic [15:0] PROP_GAIN_RST      = 16'd256;
    localparam logic [15:0] DERIV_GAIN_RST     = 16'd0;
    localparam logic [15:0] WHEEL_RATIO_RST    = 16'd16384;
    localparam logic [14:0] RAMP_STEP_RST      = 15'd256;
    localparam logic [15:0] DISTANCE_SCALE_RST = 16'd500;

    localparam logic signed [7:0]  DUTY_MAX  = 8'sd100;
    localparam logic signed [7:0]  DUTY_MIN  = -8'sd100;
    localparam logic signed [59:0] DUTY_LIM  = 60'sd419430400;
    localparam logic signed [65:0] PROD_LIM  = 66'sd72057594037927936;
    localparam logic signed [49:0] ERR_MAX   = 50'sd140737488355327;
    localparam logic signed [49:0] ERR_MIN   = -50'sd140737488355328;
    localparam logic signed [49:0] DIST_MAX  = 50'sd2147483647;
    localparam logic signed [49:0] DIST_MIN  = -50'sd2147483648;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_GO   = 2'd1,
        ACT_STOP = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        MUL_ERR,
        MUL_P,
        MUL_D,
        MUL_DIST
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ERR,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_DIST,
        ST_DUTY,
        ST_CMD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     mean_en;
        logic     err_en;
        logic     diff_en;
        logic     p_en;
        logic     pd_en;
        logic     tick_en;
        logic     cmd_en;
        logic     load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic tick_run;
        logic out_free;
    } ctl_sts_t;

    function automatic logic signed [57:0] clamp_prod(input logic signed [65:0] v);
        logic signed [65:0] c;
        c = v;
        if (v > PROD_LIM)
            c = PROD_LIM;
        else if (v < -PROD_LIM)
            c = -PROD_LIM;
        return c[57:0];
    endfunction

    function automatic logic signed [7:0] duty_out(input logic signed [59:0] v);
        logic signed [59:0] c;
        logic signed [7:0]  q;
        c = v;
        if (v > DUTY_LIM)
            c = DUTY_LIM;
        else if (v < -DUTY_LIM)
            c = -DUTY_LIM;
        q = c[29:22];
        if (c[59] && (c[21:0] != 22'd0))
            q = q + 8'sd1;
        return q;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/dds_ctrl.sv
// Sequencing state machine for the straight-drive controller.
`default_nettype none

module dds_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire dds_pkg::ctl_sts_t sts,
    output dds_pkg::ctl_cmd_t      cmd
);

    dds_pkg::state_t state_reg;
    dds_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dds_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dds_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = sts.tick_run ? dds_pkg::ST_MUL_ERR : dds_pkg::ST_CMD;
                end
            end
            dds_pkg::ST_MUL_ERR:  state_next = dds_pkg::ST_ERR;
            dds_pkg::ST_ERR:      state_next = dds_pkg::ST_MUL_P;
            dds_pkg::ST_MUL_P:    state_next = dds_pkg::ST_MUL_D;
            dds_pkg::ST_MUL_D:    state_next = dds_pkg::ST_MUL_DIST;
            dds_pkg::ST_MUL_DIST: state_next = dds_pkg::ST_DUTY;
            dds_pkg::ST_DUTY:     state_next = dds_pkg::ST_DONE;
            dds_pkg::ST_CMD:      state_next = dds_pkg::ST_DONE;
            dds_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = dds_pkg::ST_IDLE;
                end
            end
            default:              state_next = dds_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            dds_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            dds_pkg::ST_MUL_ERR:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dds_pkg::MUL_ERR;
                cmd.mean_en = 1'b1;
            end
            dds_pkg::ST_ERR:
            begin
                cmd.err_en = 1'b1;
            end
            dds_pkg::ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dds_pkg::MUL_P;
                cmd.diff_en = 1'b1;
            end
            dds_pkg::ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dds_pkg::MUL_D;
                cmd.p_en    = 1'b1;
            end
            dds_pkg::ST_MUL_DIST:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = dds_pkg::MUL_DIST;
                cmd.pd_en   = 1'b1;
            end
            dds_pkg::ST_DUTY:
            begin
                cmd.tick_en = 1'b1;
            end
            dds_pkg::ST_CMD:
            begin
                cmd.cmd_en = 1'b1;
            end
            dds_pkg::ST_DONE:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/dds_dp.sv
// Datapath: configuration, control state, shared multiplier and result register.
`default_nettype none

module dds_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire dds_pkg::ctl_cmd_t                     cmd,
    output dds_pkg::ctl_sts_t                          sts,
    input  wire logic [1:0]                            in_action,
    input  wire logic [dds_pkg::IN_DATA_W-1:0]         in_data,
    input  wire logic                                  cfg_we,
    input  wire logic [dds_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [dds_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [dds_pkg::OUT_DATA_W-1:0]             out_data
);

    logic [15:0] prop_gain_reg;
    logic [15:0] deriv_gain_reg;
    logic [15:0] wheel_ratio_reg;
    logic [14:0] ramp_step_reg;
    logic [15:0] distance_scale_reg;

    logic                mode_reg;
    logic                mode_next;
    logic signed [7:0]   target_reg;
    logic signed [7:0]   target_next;
    logic signed [17:0]  ramp_reg;
    logic signed [17:0]  ramp_next;
    logic signed [47:0]  prev_reg;
    logic signed [47:0]  prev_next;

    logic [1:0]          action_reg;
    logic signed [7:0]   speed_reg;
    logic signed [31:0]  lp_reg;
    logic signed [31:0]  rp_reg;

    logic signed [48:0]  mul_a;
    logic signed [16:0]  mul_b;
    logic signed [65:0]  prod_reg;
    logic signed [65:0]  prod_next;

    logic signed [32:0]  sum;
    logic signed [32:0]  sum_adj;
    logic signed [31:0]  mean_reg;
    logic signed [31:0]  mean_next;

    logic signed [49:0]  err_full;
    logic signed [47:0]  err_reg;
    logic signed [47:0]  err_next;
    logic signed [48:0]  diff_reg;
    logic signed [48:0]  diff_next;
    logic signed [57:0]  p_reg;
    logic signed [57:0]  p_next;
    logic signed [58:0]  pd_reg;
    logic signed [58:0]  pd_next;

    logic signed [59:0]  base;
    logic signed [18:0]  tgt;
    logic signed [18:0]  step;
    logic signed [18:0]  ramp_w;
    logic signed [49:0]  dist_neg;
    logic signed [31:0]  dist_sat;
    logic signed [7:0]   sp_clamped;

    logic signed [7:0]   res_left_reg;
    logic signed [7:0]   res_left_next;
    logic signed [7:0]   res_right_reg;
    logic signed [7:0]   res_right_next;
    logic signed [31:0]  res_dist_reg;
    logic signed [31:0]  res_dist_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [dds_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [dds_pkg::OUT_DATA_W-1:0] out_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg      <= dds_pkg::PROP_GAIN_RST;
            deriv_gain_reg     <= dds_pkg::DERIV_GAIN_RST;
            wheel_ratio_reg    <= dds_pkg::WHEEL_RATIO_RST;
            ramp_step_reg      <= dds_pkg::RAMP_STEP_RST;
            distance_scale_reg <= dds_pkg::DISTANCE_SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dds_pkg::CFG_PROP_GAIN:      prop_gain_reg      <= cfg_data;
                dds_pkg::CFG_DERIV_GAIN:     deriv_gain_reg     <= cfg_data;
                dds_pkg::CFG_WHEEL_RATIO:    wheel_ratio_reg    <= cfg_data;
                dds_pkg::CFG_RAMP_STEP:      ramp_step_reg      <= cfg_data[14:0];
                dds_pkg::CFG_DISTANCE_SCALE: distance_scale_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    assign sts.tick_run = (in_action == dds_pkg::ACT_TICK) && mode_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg <= in_action;
            speed_reg  <= $signed(in_data[7:0]);
            lp_reg     <= $signed(in_data[39:8]);
            rp_reg     <= $signed(in_data[71:40]);
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            dds_pkg::MUL_ERR:
            begin
                mul_a = 49'(lp_reg);
                mul_b = $signed({1'b0, wheel_ratio_reg});
            end
            dds_pkg::MUL_P:
            begin
                mul_a = 49'(err_reg);
                mul_b = $signed({1'b0, prop_gain_reg});
            end
            dds_pkg::MUL_D:
            begin
                mul_a = diff_reg;
                mul_b = $signed({1'b0, deriv_gain_reg});
            end
            dds_pkg::MUL_DIST:
            begin
                mul_a = 49'(mean_reg);
                mul_b = $signed({1'b0, distance_scale_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 66'(mul_a) * 66'(mul_b);

    assign sum       = 33'(lp_reg) + 33'(rp_reg);
    assign sum_adj   = sum + $signed({32'd0, sum[32]});
    assign mean_next = sum_adj[32:1];

    always_comb
    begin
        err_full = 50'($signed(prod_reg[48:0])) - (50'(rp_reg) <<< 14);
        if (err_full > dds_pkg::ERR_MAX)
            err_next = dds_pkg::ERR_MAX[47:0];
        else if (err_full < dds_pkg::ERR_MIN)
            err_next = dds_pkg::ERR_MIN[47:0];
        else
            err_next = err_full[47:0];
    end

    assign diff_next = 49'(err_reg) - 49'(prev_reg);
    assign p_next    = dds_pkg::clamp_prod(prod_reg);
    assign pd_next   = 59'(p_reg) + 59'(dds_pkg::clamp_prod(prod_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.mean_en)
            mean_reg <= mean_next;
        if (cmd.err_en)
            err_reg <= err_next;
        if (cmd.diff_en)
            diff_reg <= diff_next;
        if (cmd.p_en)
            p_reg <= p_next;
        if (cmd.pd_en)
            pd_reg <= pd_next;
    end

    always_comb
    begin
        base     = 60'(ramp_reg) <<< 14;
        tgt      = 19'(target_reg) <<< 8;
        step     = $signed({4'd0, ramp_step_reg});
        ramp_w   = 19'(ramp_reg);
        dist_neg = -(50'($signed(prod_reg[48:0])));
        if (dist_neg > dds_pkg::DIST_MAX)
            dist_sat = dds_pkg::DIST_MAX[31:0];
        else if (dist_neg < dds_pkg::DIST_MIN)
            dist_sat = dds_pkg::DIST_MIN[31:0];
        else
            dist_sat = dist_neg[31:0];
        if (speed_reg > dds_pkg::DUTY_MAX)
            sp_clamped = dds_pkg::DUTY_MAX;
        else if (speed_reg < dds_pkg::DUTY_MIN)
            sp_clamped = dds_pkg::DUTY_MIN;
        else
            sp_clamped = speed_reg;

        mode_next      = mode_reg;
        target_next    = target_reg;
        ramp_next      = ramp_reg;
        prev_next      = prev_reg;
        res_left_next  = res_left_reg;
        res_right_next = res_right_reg;
        res_dist_next  = res_dist_reg;

        if (cmd.tick_en)
        begin
            res_left_next  = dds_pkg::duty_out(base - 60'(pd_reg));
            res_right_next = dds_pkg::duty_out(base + 60'(pd_reg));
            res_dist_next  = dist_sat;
            prev_next      = err_reg;
            if (ramp_w < tgt - step)
                ramp_next = 18'(ramp_w + step);
            else if (ramp_w > tgt + step)
                ramp_next = 18'(ramp_w - step);
        end
        else if (cmd.cmd_en)
        begin
            res_left_next  = '0;
            res_right_next = '0;
            res_dist_next  = '0;
            case (action_reg)
                dds_pkg::ACT_GO:
                begin
                    target_next = -sp_clamped;
                    mode_next   = 1'b1;
                end
                dds_pkg::ACT_STOP:
                begin
                    target_next = '0;
                    ramp_next   = '0;
                    prev_next   = '0;
                    mode_next   = 1'b0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            target_reg <= '0;
            ramp_reg   <= '0;
            prev_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            target_reg <= target_next;
            ramp_reg   <= ramp_next;
            prev_reg   <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        res_dist_reg  <= res_dist_next;
    end

    assign out_valid_next = cmd.load_out ? 1'b1 : (out_valid_reg && !out_ready);
    assign out_data_next  = {7'd0, mode_reg, res_dist_reg, res_right_reg, res_left_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: hdl/diff_drive_straight_pd_ramp_core.sv
// Top level of the straight-drive PD controller with slew-limited duty ramp.
//
//   channel  direction  handshake           payload
//   s_*      in         s_tvalid/s_tready   s_tuser action, s_tdata setpoint and positions
//   m_*      out        m_tvalid/m_tready   m_tdata duties, distance, moving flag
//   cfg_*    in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// A control tick in straight mode passes states MUL_ERR, ERR, MUL_P, MUL_D, MUL_DIST, DUTY
// and DONE before the next input transfer, sequencing four products through one shared
// 49x17 multiplier. Go, stop, idle ticks and unknown actions pass only ST_CMD and ST_DONE.
// A result waits in the output register; the next input is taken meanwhile, and its
// result holds the controller until that register frees.
// Reset clears mode, setpoint, ramp and error history and loads register defaults.
// cfg_ready stays high; write registers only while the block is idle.
`default_nettype none

module diff_drive_straight_pd_ramp_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [1:0] action
    input  wire logic [1:0]                         s_tuser,
    // [7:0] speed_setpoint, [39:8] left_position, [71:40] right_position
    input  wire logic [dds_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [7:0] left_duty, [15:8] right_duty, [47:16] distance_um, [48] moving, [55:49] zero
    output logic [dds_pkg::OUT_DATA_W-1:0]          m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dds_pkg::CFG_DATA_W-1:0]     cfg_data
);

    dds_pkg::ctl_cmd_t cmd;
    dds_pkg::ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    dds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dds_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: dv/tb_diff_drive_straight_pd_ramp_core.sv
// Testbench for the straight-drive PD controller: directed and random commands against a predictor.
module tb_diff_drive_straight_pd_ramp_core;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_CAP = 100;
    localparam longint unsigned PROD_CAP = 64'd1 << 56;
    localparam longint ERR_HI = 64'sd140737488355327;
    localparam longint ERR_LO = -64'sd140737488355328;
    localparam longint DUTY_Q22 = 64'sd419430400;
    localparam longint Q22_ONE = 64'sd4194304;
    localparam longint Q14_ONE = 64'sd16384;
    localparam longint DIST_HI = 64'sd2147483647;
    localparam longint DIST_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [7:0]  left_duty;
        logic signed [7:0]  right_duty;
        logic signed [31:0] distance_um;
        logic               moving;
    } drive_out_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [1:0]                     s_tuser = '0;
    logic [dds_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dds_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dds_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dds_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic [15:0] kp = dds_pkg::PROP_GAIN_RST;
    logic [15:0] kd = dds_pkg::DERIV_GAIN_RST;
    logic [15:0] ratio = dds_pkg::WHEEL_RATIO_RST;
    logic [14:0] slew = dds_pkg::RAMP_STEP_RST;
    logic [15:0] dist_scale = dds_pkg::DISTANCE_SCALE_RST;
    logic        straight = 1'b0;
    longint      target = 0;
    longint      ramp = 0;
    longint      last_err = 0;

    drive_out_t drive_q[$];
    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int cycles = 0;

    diff_drive_straight_pd_ramp_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint sat_mul(input longint a, input longint unsigned b);
        longint unsigned mag;
        longint unsigned r;
        longint s;
        mag = (a < 0) ? -a : a;
        if (b != 0 && mag > PROD_CAP / b)
            r = PROD_CAP;
        else
            r = mag * b;
        s = r;
        return (a < 0) ? -s : s;
    endfunction

    function automatic logic signed [7:0] to_duty(input longint q);
        longint c;
        c = q;
        if (c > DUTY_Q22)
            c = DUTY_Q22;
        if (c < -DUTY_Q22)
            c = -DUTY_Q22;
        c = c / Q22_ONE;
        return c[7:0];
    endfunction

    function automatic drive_out_t step_controller(input logic [1:0] act,
                                                   input logic signed [7:0] sp,
                                                   input logic signed [31:0] lpos,
                                                   input logic signed [31:0] rpos);
        drive_out_t res;
        longint sp_l, lp, rp, err, pd, base, tgt, mean, d;
        longint ratio_l, step_l, scale_l;
        res = '0;
        if (act == dds_pkg::ACT_GO)
        begin
            sp_l = sp;
            if (sp_l > 100)
                sp_l = 100;
            if (sp_l < -100)
                sp_l = -100;
            target = -sp_l;
            straight = 1'b1;
        end
        else if (act == dds_pkg::ACT_STOP)
        begin
            target = 0;
            ramp = 0;
            last_err = 0;
            straight = 1'b0;
        end
        else if (act == dds_pkg::ACT_TICK && straight)
        begin
            lp = lpos;
            rp = rpos;
            ratio_l = ratio;
            err = lp * ratio_l - rp * Q14_ONE;
            if (err > ERR_HI)
                err = ERR_HI;
            if (err < ERR_LO)
                err = ERR_LO;
            pd = sat_mul(err, kp) + sat_mul(err - last_err, kd);
            last_err = err;
            base = ramp * Q14_ONE;
            res.left_duty = to_duty(base - pd);
            res.right_duty = to_duty(base + pd);
            step_l = slew;
            tgt = target * 256;
            if (ramp < tgt - step_l)
                ramp = ramp + step_l;
            if (ramp > tgt + step_l)
                ramp = ramp - step_l;
            mean = (lp + rp) / 2;
            scale_l = dist_scale;
            d = -(mean * scale_l);
            if (d > DIST_HI)
                d = DIST_HI;
            if (d < DIST_LO)
                d = DIST_LO;
            res.distance_um = d[31:0];
        end
        res.moving = straight;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    endtask

    always @(posedge clk)
    begin
        drive_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (drive_q.size() == 0)
                report_mismatch("unexpected output", m_tdata[31:0], '0);
            else
            begin
                want = drive_q.pop_front();
                if (m_tdata[7:0] !== want.left_duty)
                    report_mismatch("left_duty", m_tdata[7:0], want.left_duty);
                if (m_tdata[15:8] !== want.right_duty)
                    report_mismatch("right_duty", m_tdata[15:8], want.right_duty);
                if (m_tdata[47:16] !== want.distance_um)
                    report_mismatch("distance_um", m_tdata[47:16], want.distance_um);
                if (m_tdata[48] !== want.moving)
                    report_mismatch("moving", m_tdata[48], want.moving);
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_cmd(input logic [1:0] act, input logic signed [7:0] sp,
                            input logic signed [31:0] lpos, input logic signed [31:0] rpos);
        drive_out_t pred;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {rpos, lpos, sp};
        do
            @(posedge clk);
        while (!s_tready);
        pred = step_controller(act, sp, lpos, rpos);
        drive_q = {drive_q, pred};
    endtask

    task automatic wait_outputs_done();
        s_tvalid <= 1'b0;
        while (drive_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] p, input logic [15:0] d,
                                input logic [15:0] w, input logic [15:0] r,
                                input logic [15:0] s);
        logic [dds_pkg::CFG_IDX_W-1:0] idx [6];
        logic [15:0]                   val [6];
        wait_outputs_done();
        idx[0] = dds_pkg::CFG_DISTANCE_SCALE + 3'($urandom_range(3, 1));
        val[0] = 16'($urandom);
        idx[1] = dds_pkg::CFG_PROP_GAIN;
        val[1] = p;
        idx[2] = dds_pkg::CFG_DERIV_GAIN;
        val[2] = d;
        idx[3] = dds_pkg::CFG_WHEEL_RATIO;
        val[3] = w;
        idx[4] = dds_pkg::CFG_RAMP_STEP;
        val[4] = r;
        idx[5] = dds_pkg::CFG_DISTANCE_SCALE;
        val[5] = s;
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                dds_pkg::CFG_PROP_GAIN:      kp = val[i];
                dds_pkg::CFG_DERIV_GAIN:     kd = val[i];
                dds_pkg::CFG_WHEEL_RATIO:    ratio = val[i];
                dds_pkg::CFG_RAMP_STEP:      slew = val[i][14:0];
                dds_pkg::CFG_DISTANCE_SCALE: dist_scale = val[i];
                default:                     ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_reg(input int lo, input int hi);
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 16'($urandom_range(hi, lo));
        else if (roll < 85)
            return 16'($urandom);
        else if (roll < 93)
            return 16'd0;
        else
            return 16'hffff;
    endfunction

    function automatic logic signed [7:0] pick_setpoint();
        if ($urandom_range(99) < 85)
            return 8'(int'($urandom_range(200)) - 100);
        else
            return 8'($urandom);
    endfunction

    task automatic pick_positions(output logic signed [31:0] l, output logic signed [31:0] r);
        int kind;
        int base;
        logic signed [31:0] corners [4];
        corners[0] = 32'h7fffffff;
        corners[1] = 32'h80000000;
        corners[2] = 32'h0;
        corners[3] = 32'hffffffff;
        kind = $urandom_range(9);
        if (kind < 2)
        begin
            l = $urandom;
            r = $urandom;
        end
        else if (kind < 3)
        begin
            l = corners[$urandom_range(3)];
            r = corners[$urandom_range(3)];
        end
        else
        begin
            base = int'($urandom_range(2000000)) - 1000000;
            l = base;
            r = base + int'($urandom_range(120)) - 60;
        end
    endtask

    task automatic run_drive_session(input int n_items);
        int counted, roll, run_len;
        logic signed [31:0] l, r;
        counted = 0;
        while (counted < n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                send_cmd(dds_pkg::ACT_GO, pick_setpoint(), $urandom, $urandom);
                counted++;
                run_len = $urandom_range(60, 3);
                for (int k = 0; k < run_len; k++)
                begin
                    if ($urandom_range(99) < 4)
                        send_cmd(dds_pkg::ACT_GO, pick_setpoint(), $urandom, $urandom);
                    else
                    begin
                        pick_positions(l, r);
                        send_cmd(dds_pkg::ACT_TICK, 8'($urandom), l, r);
                    end
                    counted++;
                end
            end
            else if (roll < 80)
            begin
                send_cmd(dds_pkg::ACT_STOP, 8'($urandom), $urandom, $urandom);
                counted++;
            end
            else if (roll < 88)
                send_cmd(ACT_UNUSED, 8'($urandom), $urandom, $urandom);
            else
            begin
                if (straight)
                    counted++;
                pick_positions(l, r);
                send_cmd(dds_pkg::ACT_TICK, 8'($urandom), l, r);
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, 32'h7fffffff, 32'h80000000);
        send_cmd(ACT_UNUSED, 8'sd5, 32'd1, 32'd2);
        send_cmd(dds_pkg::ACT_GO, 8'sd100, 32'd0, 32'd0);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, 32'sd1000, 32'sd990);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, 32'h80000000, 32'h80000000);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, 32'd0, 32'd0);
    endtask

    task automatic test_commands();
        send_cmd(dds_pkg::ACT_GO, 8'sd127, 32'd0, 32'd0);
        send_cmd(dds_pkg::ACT_GO, -8'sd128, 32'd0, 32'd0);
        send_cmd(ACT_UNUSED, 8'sd0, 32'd0, 32'd0);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, 32'sd500, -32'sd500);
        send_cmd(dds_pkg::ACT_STOP, 8'sd0, 32'd0, 32'd0);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, 32'sd40, 32'sd20);
        send_cmd(dds_pkg::ACT_GO, -8'sd100, 32'd0, 32'd0);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, -32'sd7, 32'sd3);
    endtask

    task automatic test_extremes();
        program_regs(16'hffff, 16'hffff, 16'hffff, 16'd25600, 16'hffff);
        send_cmd(dds_pkg::ACT_GO, 8'sd100, 32'd0, 32'd0);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, 32'h7fffffff, 32'h80000000);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, 32'h80000000, 32'h7fffffff);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, 32'h7fffffff, 32'h7fffffff);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, 32'h80000000, 32'h80000000);
        program_regs(16'd0, 16'd0, 16'd0, 16'hffff, 16'd0);
        send_cmd(dds_pkg::ACT_GO, -8'sd50, 32'd0, 32'd0);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, $urandom, $urandom);
        send_cmd(dds_pkg::ACT_TICK, 8'sd0, $urandom, $urandom);
        send_cmd(dds_pkg::ACT_STOP, 8'sd0, 32'd0, 32'd0);
    endtask

    task automatic test_random_drive();
        int idle_mix [4];
        int stall_mix [4];
        idle_mix[0] = 0;
        stall_mix[0] = 0;
        idle_mix[1] = 58;
        stall_mix[1] = 0;
        idle_mix[2] = 0;
        stall_mix[2] = 58;
        idle_mix[3] = 29;
        stall_mix[3] = 29;
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_mix[ph];
            stall_pct = stall_mix[ph];
            for (int blk = 0; blk < 3; blk++)
            begin
                program_regs(pick_reg(0, 1024), pick_reg(0, 2048), pick_reg(15000, 18000),
                             pick_reg(0, 25600), pick_reg(0, 2000));
                run_drive_session(150);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_commands();
        test_extremes();
        test_random_drive();
        wait_outputs_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
